[design/pcrc_pkg.sv]
`timescale 1ns / 1ps

package pcrc_pkg;

    // coordinate width of every point, edge and result field
    localparam int COORD_WIDTH = 16;

    // queue depths between the front, the back and the result port
    localparam int JOB_FIFO_DEPTH = 2;
    localparam int RES_FIFO_DEPTH = 2;

    // configuration port
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_RIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_BOTTOM = 3'd3;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    localparam coord_t RST_CLIP_LEFT   = coord_t'(0);
    localparam coord_t RST_CLIP_RIGHT  = coord_t'(639);
    localparam coord_t RST_CLIP_TOP    = coord_t'(0);
    localparam coord_t RST_CLIP_BOTTOM = coord_t'(479);

    // pen commands
    localparam logic CMD_MOVE = 1'b0;
    localparam logic CMD_LINE = 1'b1;

    typedef struct packed {
        coord_t clip_left;
        coord_t clip_right;
        coord_t clip_top;
        coord_t clip_bottom;
    } cfg_t;

    typedef struct packed {
        coord_t point_x;
        coord_t point_y;
        logic   first_point;
    } in_t;

    typedef struct packed {
        logic   command;
        coord_t out_x;
        coord_t out_y;
        logic   last_of_run;
    } out_t;

    typedef enum logic [1:0] {
        JOB_FIRST = 2'd0,   // move to the vertex
        JOB_LINE  = 2'd1,   // line to the vertex
        JOB_EXIT  = 2'd2,   // inside to outside crossing
        JOB_ENTER = 2'd3    // outside to inside crossing
    } job_kind_t;

    // in_x/in_y: the inside point (or the vertex itself), out_x/out_y: the outside point
    typedef struct packed {
        job_kind_t kind;
        coord_t    in_x;
        coord_t    in_y;
        coord_t    out_x;
        coord_t    out_y;
    } job_t;

endpackage

[design/pcrc_fifo.sv]
`timescale 1ns / 1ps

module pcrc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             wr_en;
    logic             rd_en;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign wr_en = push && !full;
    assign rd_en = pop && !empty;
    assign dout  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    // a refused push leaves the fill level alone
    a_full_push_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (push && full && !pop) |=> $stable(count_reg))
        else $error("queue fill level moved on a refused push");

endmodule

[design/pcrc_front.sv]
`timescale 1ns / 1ps

module pcrc_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  pcrc_pkg::in_t    vertex,
    input  pcrc_pkg::cfg_t   cfg,
    input  logic             job_full,
    output logic             job_push,
    output pcrc_pkg::job_t   job
);

    pcrc_pkg::coord_t prev_x_reg, prev_x_next;
    pcrc_pkg::coord_t prev_y_reg, prev_y_next;
    logic             prev_inside_reg, prev_inside_next;
    logic             accept;
    logic             vtx_inside;
    logic             emits;

    assign full   = job_full;
    assign accept = push && !job_full;
    assign vtx_inside = (cfg.clip_left <= vertex.point_x) && (vertex.point_x <= cfg.clip_right) &&
                        (cfg.clip_top <= vertex.point_y) && (vertex.point_y <= cfg.clip_bottom);

    always_comb
    begin
        job.kind  = pcrc_pkg::JOB_FIRST;
        job.in_x  = vertex.point_x;
        job.in_y  = vertex.point_y;
        job.out_x = prev_x_reg;
        job.out_y = prev_y_reg;
        emits     = 1'b1;
        if (vertex.first_point)
        begin
            job.kind = pcrc_pkg::JOB_FIRST;
        end
        else if (prev_inside_reg && vtx_inside)
        begin
            job.kind = pcrc_pkg::JOB_LINE;
        end
        else if (prev_inside_reg)
        begin
            job.kind  = pcrc_pkg::JOB_EXIT;
            job.in_x  = prev_x_reg;
            job.in_y  = prev_y_reg;
            job.out_x = vertex.point_x;
            job.out_y = vertex.point_y;
        end
        else if (vtx_inside)
        begin
            job.kind = pcrc_pkg::JOB_ENTER;
        end
        else
        begin
            // outside to outside: nothing to draw
            emits = 1'b0;
        end
    end

    assign job_push = accept && emits;

    always_comb
    begin
        prev_x_next      = prev_x_reg;
        prev_y_next      = prev_y_reg;
        prev_inside_next = prev_inside_reg;
        if (accept)
        begin
            prev_x_next      = vertex.point_x;
            prev_y_next      = vertex.point_y;
            prev_inside_next = vtx_inside;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg      <= '0;
            prev_y_reg      <= '0;
            prev_inside_reg <= 1'b0;
        end
        else
        begin
            prev_x_reg      <= prev_x_next;
            prev_y_reg      <= prev_y_next;
            prev_inside_reg <= prev_inside_next;
        end
    end

endmodule

[design/pcrc_back.sv]
`timescale 1ns / 1ps

module pcrc_back (
    input  logic             clk,
    input  logic             rst_n,
    input  pcrc_pkg::cfg_t   cfg,
    input  logic             job_empty,
    input  pcrc_pkg::job_t   job,
    output logic             job_pop,
    input  logic             res_full,
    output logic             res_push,
    output pcrc_pkg::out_t   res
);

    localparam int CW    = pcrc_pkg::COORD_WIDTH;
    localparam int DW    = CW + 1;          // magnitudes and divisor
    localparam int QW    = 2 * DW;          // product, dividend and quotient
    localparam int VW    = QW + 2;          // interpolated value before range check
    localparam int CNT_W = $clog2(QW);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SETUP = 7'b0000010,
        S_MUL   = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_FIX   = 7'b0010000,
        S_EMIT0 = 7'b0100000,
        S_EMIT1 = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;
    logic               pass_reg, pass_next;        // 0: x edge, 1: y edge
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    pcrc_pkg::job_t     job_reg, job_next;
    logic [DW-1:0]      a_reg, a_next;
    logic [DW-1:0]      b_reg, b_next;
    logic [DW-1:0]      d_reg, d_next;
    logic               neg_reg, neg_next;
    pcrc_pkg::coord_t   io_reg, io_next;
    pcrc_pkg::coord_t   edge_reg, edge_next;
    logic [DW-1:0]      rem_reg, rem_next;
    logic [QW-1:0]      lo_reg, lo_next;
    logic [QW-1:0]      q_reg, q_next;
    pcrc_pkg::coord_t   bx_reg, bx_next;
    pcrc_pkg::coord_t   by_reg, by_next;

    // setup: operands for the current pass
    pcrc_pkg::coord_t   ip, io, op, oo, edge_sel;
    logic               lo_side;
    logic               cond;
    logic signed [DW-1:0] den, dn, dp;
    logic [DW-1:0]      den_abs, dn_abs, dp_abs;

    // multiply and divide
    logic [QW-1:0]      prod;
    logic [DW:0]        trial;
    logic [DW:0]        diff;
    logic               ge;

    // fix-up
    logic signed [VW-1:0] io_ext, q_ext, vsum, vfix, top_ext, bot_ext;
    logic               in_range;

    always_comb
    begin
        if (!pass_reg)
        begin
            ip       = job_reg.in_x;
            io       = job_reg.in_y;
            op       = job_reg.out_x;
            oo       = job_reg.out_y;
            lo_side  = op < cfg.clip_left;
            edge_sel = lo_side ? cfg.clip_left : cfg.clip_right;
            cond     = (lo_side && ip >= cfg.clip_left) ||
                       (op > cfg.clip_right && ip <= cfg.clip_right);
        end
        else
        begin
            ip       = job_reg.in_y;
            io       = job_reg.in_x;
            op       = job_reg.out_y;
            oo       = job_reg.out_x;
            lo_side  = op < cfg.clip_top;
            edge_sel = lo_side ? cfg.clip_top : cfg.clip_bottom;
            cond     = (lo_side && ip >= cfg.clip_top) ||
                       (op > cfg.clip_bottom && ip <= cfg.clip_bottom);
        end
        den     = {op[CW-1], op} - {ip[CW-1], ip};
        dn      = {oo[CW-1], oo} - {io[CW-1], io};
        dp      = {edge_sel[CW-1], edge_sel} - {ip[CW-1], ip};
        den_abs = den[DW-1] ? (~den + DW'(1)) : den;
        dn_abs  = dn[DW-1]  ? (~dn + DW'(1))  : dn;
        dp_abs  = dp[DW-1]  ? (~dp + DW'(1))  : dp;
    end

    assign prod  = a_reg * b_reg;
    assign trial = {rem_reg, lo_reg[QW-1]};
    assign diff  = trial - {1'b0, d_reg};
    assign ge    = trial >= {1'b0, d_reg};

    // truncate toward zero after the floor of the magnitude
    always_comb
    begin
        io_ext  = {{(VW-CW){io_reg[CW-1]}}, io_reg};
        q_ext   = {2'b00, q_reg};
        top_ext = {{(VW-CW){cfg.clip_top[CW-1]}}, cfg.clip_top};
        bot_ext = {{(VW-CW){cfg.clip_bottom[CW-1]}}, cfg.clip_bottom};
        vsum    = neg_reg ? (io_ext - q_ext) : (io_ext + q_ext);
        vfix    = vsum;
        if (rem_reg != '0)
        begin
            if (!neg_reg && vsum[VW-1])
            begin
                vfix = vsum + VW'(1);
            end
            else if (neg_reg && !vsum[VW-1] && vsum != '0)
            begin
                vfix = vsum - VW'(1);
            end
        end
        in_range = (vfix >= top_ext) && (vfix <= bot_ext);
    end

    assign job_pop  = (state_reg == S_IDLE) && !job_empty;
    assign res_push = ((state_reg == S_EMIT0) || (state_reg == S_EMIT1)) && !res_full;

    always_comb
    begin
        res.command     = pcrc_pkg::CMD_MOVE;
        res.out_x       = job_reg.in_x;
        res.out_y       = job_reg.in_y;
        res.last_of_run = (state_reg == S_EMIT1);
        if (state_reg == S_EMIT0)
        begin
            if (job_reg.kind != pcrc_pkg::JOB_EXIT)
            begin
                res.out_x = bx_reg;
                res.out_y = by_reg;
            end
        end
        else
        begin
            unique case (job_reg.kind)
                pcrc_pkg::JOB_FIRST:
                begin
                    res.command = pcrc_pkg::CMD_MOVE;
                end
                pcrc_pkg::JOB_LINE, pcrc_pkg::JOB_ENTER:
                begin
                    res.command = pcrc_pkg::CMD_LINE;
                end
                pcrc_pkg::JOB_EXIT:
                begin
                    res.command = pcrc_pkg::CMD_LINE;
                    res.out_x   = bx_reg;
                    res.out_y   = by_reg;
                end
                default:
                begin
                    res.command = pcrc_pkg::CMD_MOVE;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        cnt_next   = cnt_reg;
        job_next   = job_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        d_next     = d_reg;
        neg_next   = neg_reg;
        io_next    = io_reg;
        edge_next  = edge_reg;
        rem_next   = rem_reg;
        lo_next    = lo_reg;
        q_next     = q_reg;
        bx_next    = bx_reg;
        by_next    = by_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!job_empty)
                begin
                    job_next  = job;
                    pass_next = 1'b0;
                    if (job.kind == pcrc_pkg::JOB_FIRST || job.kind == pcrc_pkg::JOB_LINE)
                    begin
                        state_next = S_EMIT1;
                    end
                    else
                    begin
                        state_next = S_SETUP;
                    end
                end
            end
            S_SETUP:
            begin
                if (cond)
                begin
                    a_next     = dn_abs;
                    b_next     = dp_abs;
                    d_next     = den_abs;
                    neg_next   = dn[DW-1] ^ den[DW-1] ^ dp[DW-1];
                    io_next    = io;
                    edge_next  = edge_sel;
                    state_next = S_MUL;
                end
                else if (!pass_reg)
                begin
                    pass_next = 1'b1;
                end
                else
                begin
                    // no edge fits: fall back to the outside point
                    bx_next    = job_reg.out_x;
                    by_next    = job_reg.out_y;
                    state_next = S_EMIT0;
                end
            end
            S_MUL:
            begin
                // whole product is divided: on an inverted rectangle the
                // quotient can run well past the coordinate range
                rem_next   = '0;
                lo_next    = prod;
                q_next     = '0;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
                q_next   = {q_reg[QW-2:0], ge};
                lo_next  = {lo_reg[QW-2:0], 1'b0};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(QW - 1))
                begin
                    state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                if (!pass_reg)
                begin
                    if (in_range)
                    begin
                        bx_next    = edge_reg;
                        by_next    = vfix[CW-1:0];
                        state_next = S_EMIT0;
                    end
                    else
                    begin
                        pass_next  = 1'b1;
                        state_next = S_SETUP;
                    end
                end
                else
                begin
                    bx_next    = vfix[CW-1:0];
                    by_next    = edge_reg;
                    state_next = S_EMIT0;
                end
            end
            S_EMIT0:
            begin
                if (!res_full)
                begin
                    state_next = S_EMIT1;
                end
            end
            S_EMIT1:
            begin
                if (!res_full)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pass_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        d_reg    <= d_next;
        neg_reg  <= neg_next;
        io_reg   <= io_next;
        edge_reg <= edge_next;
        rem_reg  <= rem_next;
        lo_reg   <= lo_next;
        q_reg    <= q_next;
        bx_reg   <= bx_next;
        by_reg   <= by_next;
    end

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |-> (d_reg != '0))
        else $error("boundary interpolation started with a zero divisor");

    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < d_reg))
        else $error("divider remainder not below divisor");

    a_rem_final: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIX) |-> (rem_reg < d_reg))
        else $error("final remainder not below divisor");

endmodule

[design/polyline_rect_clipper_top.sv]
`timescale 1ns / 1ps

// Polyline clipper against an inclusive rectangle. Vertices are pushed in as
// transactions on a queue-style port (push/full) and pen commands come out of a
// queue-style port (empty/pop); each vertex gives zero, one or two commands and
// last_of_run marks the final one. The front takes one vertex per cycle while the
// job queue has room: it tests the vertex against the rectangle, keeps the
// previous vertex, and queues a job unless both vertices are outside. The back works
// on one job at a time. Move and inside-to-inside line jobs go from idle straight to
// the final emit state. A crossing needs the boundary point: each edge tried goes
// through setup, multiply, divide and fix-up, the divide done by the one-bit-per-cycle
// restoring divider in the back sequencer, which runs over the whole product; the x
// edge is tried first, the y edge when the x edge does not fit. A full result queue
// stalls the emit states. The four clip registers are written through cfg_valid/cfg_ready and
// should only change while no vertex is in flight; indexes beyond the register
// list are ignored. Reset rectangle is 0..639 by 0..479.
module polyline_rect_clipper_top #(
    parameter int JOB_DEPTH = pcrc_pkg::JOB_FIFO_DEPTH,
    parameter int RES_DEPTH = pcrc_pkg::RES_FIFO_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // vertex transactions
    input  logic                              push,
    output logic                              full,
    input  pcrc_pkg::in_t                     vertex,
    // command transactions
    output logic                              empty,
    input  logic                              pop,
    output pcrc_pkg::out_t                    result,
    // register writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pcrc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  pcrc_pkg::coord_t                  cfg_data
);

    pcrc_pkg::cfg_t  cfg_reg, cfg_next;

    logic            job_push;
    logic            job_full;
    logic            job_pop;
    logic            job_empty;
    pcrc_pkg::job_t  job_in;
    pcrc_pkg::job_t  job_out;
    logic [$bits(pcrc_pkg::job_t)-1:0] job_dout;

    logic            res_push;
    logic            res_full;
    pcrc_pkg::out_t  res_in;
    logic [$bits(pcrc_pkg::out_t)-1:0] res_dout;

    // register bank: writes are always taken
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                pcrc_pkg::REG_CLIP_LEFT:   cfg_next.clip_left   = cfg_data;
                pcrc_pkg::REG_CLIP_RIGHT:  cfg_next.clip_right  = cfg_data;
                pcrc_pkg::REG_CLIP_TOP:    cfg_next.clip_top    = cfg_data;
                pcrc_pkg::REG_CLIP_BOTTOM: cfg_next.clip_bottom = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clip_left   <= pcrc_pkg::RST_CLIP_LEFT;
            cfg_reg.clip_right  <= pcrc_pkg::RST_CLIP_RIGHT;
            cfg_reg.clip_top    <= pcrc_pkg::RST_CLIP_TOP;
            cfg_reg.clip_bottom <= pcrc_pkg::RST_CLIP_BOTTOM;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: classify and keep the previous vertex
    pcrc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .vertex   (vertex),
        .cfg      (cfg_reg),
        .job_full (job_full),
        .job_push (job_push),
        .job      (job_in)
    );

    // jobs between front and back
    pcrc_fifo #(
        .WIDTH ($bits(pcrc_pkg::job_t)),
        .DEPTH (JOB_DEPTH)
    ) u_job_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .din   (job_in),
        .full  (job_full),
        .pop   (job_pop),
        .dout  (job_dout),
        .empty (job_empty)
    );

    assign job_out = pcrc_pkg::job_t'(job_dout);

    // back: boundary point and command sequencing
    pcrc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_empty (job_empty),
        .job       (job_out),
        .job_pop   (job_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    // result queue: holds commands while the consumer stalls; the back waits when it is full
    pcrc_fifo #(
        .WIDTH ($bits(pcrc_pkg::out_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_in),
        .full  (res_full),
        .pop   (pop),
        .dout  (res_dout),
        .empty (empty)
    );

    assign result = pcrc_pkg::out_t'(res_dout);

endmodule

[verif/tb_polyline_rect_clipper_top.sv]
`timescale 1ns / 1ps

// Self-checking bench for the polyline clipper.
//  - vertex transactions go in on push/full; pen command transactions come out on
//    empty/pop; clip registers are written over cfg_valid/cfg_ready
//  - an in-bench model of the clipper predicts the commands of every accepted
//    vertex; the monitor compares each popped command field by field with the
//    oldest prediction
//  - a short directed table goes first, then random polylines under a range of
//    clip rectangles (tiny, full range, inverted, a single point, another single
//    point at the extremes, random, reset values)
module tb_polyline_rect_clipper_top;
    import pcrc_pkg::*;

    // index with no register behind it; the block must ignore the write
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    // quiet cycles before a register write, on top of waiting for the last command
    localparam int SETTLE_CYCLES = 80;
    localparam int MAX_REPORTS   = 100;

    // one row of stimulus: a vertex and, where obvious, the commands it must give
    typedef struct {
        in_t  v;
        bit   typed;
        int   n;
        out_t e0;
        out_t e1;
    } row_t;

    logic   clk       = 1'b0;
    logic   rst_n     = 1'b0;
    logic   push      = 1'b0;
    logic   full;
    in_t    vertex    = '0;
    logic   empty;
    logic   pop       = 1'b0;
    out_t   result;
    logic   cfg_valid = 1'b0;
    logic   cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    coord_t cfg_data  = '0;

    // model state: clip box plus the stored previous vertex
    cfg_t   clip_box;
    coord_t last_x;
    coord_t last_y;
    bit     last_inside;

    out_t   pending_pen_cmds[$];   // predicted commands not yet popped
    row_t   directed_rows[$];
    int     mismatch_count = 0;
    int     burst_left     = 0;
    int     stall_pct      = 0;
    int     stall_left     = 0;

    polyline_rect_clipper_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .vertex    (vertex),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Model of the clipper
    // ------------------------------------------------------------------

    function automatic bit in_box(input longint x, input longint y);
        return longint'(clip_box.clip_left) <= x && x <= longint'(clip_box.clip_right) &&
               longint'(clip_box.clip_top) <= y && y <= longint'(clip_box.clip_bottom);
    endfunction

    // other coordinate where the segment meets par == at; exact, truncated toward zero
    function automatic longint edge_cross(input longint ip, input longint io,
                                          input longint op, input longint oo,
                                          input longint at);
        longint den, dn, dp, a, b, d, prod, q, r, v;
        bit     neg;
        den = op - ip;
        dn  = oo - io;
        dp  = at - ip;
        if (den == 0)
        begin
            v = io;
        end
        else
        begin
            d    = (den < 0) ? -den : den;
            a    = (dn < 0) ? -dn : dn;
            b    = (dp < 0) ? -dp : dp;
            prod = a * b;             // below 2^34, no overflow
            q    = prod / d;
            r    = prod % d;
            neg  = ((dn < 0) != (den < 0)) != (dp < 0);
            if (!neg)
            begin
                v = io + q;
                if (r != 0 && v < 0)
                    v = v + 1;
            end
            else
            begin
                v = io - q;
                if (r != 0 && v > 0)
                    v = v - 1;
            end
        end
        return v;
    endfunction

    // x edge on the outside point's side first, then the y edge; if neither
    // side test holds (stale inside flag) the outside point itself is used
    function automatic void find_boundary(input longint ix, input longint iy,
                                          input longint ox, input longint oy,
                                          output longint bx, output longint by);
        longint l, r, t, b, at, yy;
        bit     done;
        l    = longint'(clip_box.clip_left);
        r    = longint'(clip_box.clip_right);
        t    = longint'(clip_box.clip_top);
        b    = longint'(clip_box.clip_bottom);
        bx   = ox;
        by   = oy;
        done = 1'b0;
        if ((ox < l && ix >= l) || (ox > r && ix <= r))
        begin
            at = (ox < l) ? l : r;
            yy = edge_cross(ix, iy, ox, oy, at);
            if (yy >= t && yy <= b)
            begin
                bx   = at;
                by   = yy;
                done = 1'b1;
            end
        end
        if (!done && ((oy < t && iy >= t) || (oy > b && iy <= b)))
        begin
            at = (oy < t) ? t : b;
            bx = edge_cross(iy, ix, oy, ox, at);
            by = at;
        end
    endfunction

    function automatic out_t pen_cmd(input logic cmd, input longint x, input longint y,
                                     input logic is_last);
        out_t c;
        c.command     = cmd;
        c.out_x       = coord_t'(x);
        c.out_y       = coord_t'(y);
        c.last_of_run = is_last;
        return c;
    endfunction

    // commands for one vertex; also moves the vertex into the stored state
    function automatic int clip_vertex(input in_t v, output out_t c0, output out_t c1);
        longint x, y, px, py, bx, by;
        bit     inside_now;
        int     n;
        x          = longint'(v.point_x);
        y          = longint'(v.point_y);
        px         = longint'(last_x);
        py         = longint'(last_y);
        inside_now = in_box(x, y);
        c0         = '0;
        c1         = '0;
        n          = 0;
        if (v.first_point)
        begin
            c0 = pen_cmd(CMD_MOVE, x, y, 1'b1);
            n  = 1;
        end
        else if (last_inside && inside_now)
        begin
            c0 = pen_cmd(CMD_LINE, x, y, 1'b1);
            n  = 1;
        end
        else if (last_inside)
        begin
            find_boundary(px, py, x, y, bx, by);
            c0 = pen_cmd(CMD_MOVE, px, py, 1'b0);
            c1 = pen_cmd(CMD_LINE, bx, by, 1'b1);
            n  = 2;
        end
        else if (inside_now)
        begin
            find_boundary(x, y, px, py, bx, by);
            c0 = pen_cmd(CMD_MOVE, bx, by, 1'b0);
            c1 = pen_cmd(CMD_LINE, x, y, 1'b1);
            n  = 2;
        end
        last_x      = v.point_x;
        last_y      = v.point_y;
        last_inside = inside_now;
        return n;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic flag_mismatch(input string msg);
        if (mismatch_count < MAX_REPORTS)
            $display("%0t ns: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_pen_cmd(input out_t got);
        out_t want;
        if (pending_pen_cmds.size() == 0)
        begin
            flag_mismatch($sformatf("unexpected command %0d to (%0d,%0d) last %0d",
                                    got.command, got.out_x, got.out_y, got.last_of_run));
        end
        else
        begin
            want = pending_pen_cmds.pop_front();
            if (got.command !== want.command)
                flag_mismatch($sformatf("command %0d, want %0d", got.command, want.command));
            if (got.out_x !== want.out_x)
                flag_mismatch($sformatf("out_x %0d, want %0d", got.out_x, want.out_x));
            if (got.out_y !== want.out_y)
                flag_mismatch($sformatf("out_y %0d, want %0d", got.out_y, want.out_y));
            if (got.last_of_run !== want.last_of_run)
                flag_mismatch($sformatf("last_of_run %0d, want %0d",
                                        got.last_of_run, want.last_of_run));
        end
    endtask

    // result transactions are taken at the rising edge, values as they were before it
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            check_pen_cmd(result);
    end

    // receiver: pop with a stall rate drawn afresh whenever its random stretch runs out;
    // the zero rate gives stretches of back-to-back pops
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            case ($urandom_range(3))
                0: stall_pct = 0;
                1: stall_pct = 25;
                2: stall_pct = 60;
                default: stall_pct = 90;
            endcase
            stall_left = $urandom_range(128, 32);
        end
        stall_left--;
        pop <= ($urandom_range(99) >= stall_pct);
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // one vertex transaction; the row's typed commands, where given, stand in for
    // the prediction (the model still steps to keep its state)
    task automatic send_vertex(input row_t r);
        out_t c0, c1;
        int   n;
        @(negedge clk);
        push   <= 1'b1;
        vertex <= r.v;
        @(posedge clk);
        while (full)
            @(posedge clk);
        n = clip_vertex(r.v, c0, c1);
        if (r.typed)
        begin
            n  = r.n;
            c0 = r.e0;
            c1 = r.e1;
        end
        if (n > 0)
            pending_pen_cmds.push_back(c0);
        if (n > 1)
            pending_pen_cmds.push_back(c1);
    endtask

    // sender idles in bursts; now and then it holds off until every command is out
    task automatic pace_sender();
        int gap;
        if ($urandom_range(199) == 0)
        begin
            @(negedge clk);
            push <= 1'b0;
            while (pending_pen_cmds.size() != 0)
                @(posedge clk);
        end
        else if (burst_left == 0)
        begin
            gap = ($urandom_range(9) < 3) ? 0 : $urandom_range(8, 1);
            if (gap > 0)
            begin
                @(negedge clk);
                push <= 1'b0;
                repeat (gap - 1)
                    @(negedge clk);
            end
            burst_left = $urandom_range(16, 1);
        end
        if (burst_left > 0)
            burst_left--;
    endtask

    // block idle: sender quiet, every command popped, back end given time to finish
    task automatic settle();
        @(negedge clk);
        push <= 1'b0;
        while (pending_pen_cmds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        burst_left = 0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input coord_t data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_CLIP_LEFT:   clip_box.clip_left   = data;
            REG_CLIP_RIGHT:  clip_box.clip_right  = data;
            REG_CLIP_TOP:    clip_box.clip_top    = data;
            REG_CLIP_BOTTOM: clip_box.clip_bottom = data;
            default: ;
        endcase
    endtask

    function automatic row_t typed_row(input int x, input int y, input bit first, input int n,
                                       input logic cmd0, input int x0, input int y0,
                                       input logic cmd1, input int x1, input int y1);
        row_t r;
        r.v.point_x     = coord_t'(x);
        r.v.point_y     = coord_t'(y);
        r.v.first_point = first;
        r.typed         = 1'b1;
        r.n             = n;
        r.e0            = pen_cmd(cmd0, x0, y0, n == 1);
        r.e1            = pen_cmd(cmd1, x1, y1, 1'b1);
        return r;
    endfunction

    function automatic row_t checked_row(input int x, input int y, input bit first);
        row_t r;
        r = typed_row(x, y, first, 0, CMD_MOVE, 0, 0, CMD_MOVE, 0, 0);
        r.typed = 1'b0;
        return r;
    endfunction

    // coordinate biased toward the band lo..hi and its edges, with some full-range values
    function automatic coord_t rand_near(input coord_t lo, input coord_t hi);
        longint a, b, span, v;
        int     mode;
        a    = (lo < hi) ? longint'(lo) : longint'(hi);
        b    = (lo < hi) ? longint'(hi) : longint'(lo);
        span = b - a + 1;
        mode = $urandom_range(99);
        if (mode < 15)
            v = longint'(coord_t'($urandom));
        else if (mode < 30)
            v = (($urandom_range(1) == 0) ? a : b) + longint'($urandom_range(2)) - 1;
        else if (mode < 65)
            v = a + longint'($urandom) % span;
        else
            v = a - span / 2 - 8 + longint'($urandom) % (2 * span + 16);
        if (v < -32768)
            v = -32768;
        if (v > 32767)
            v = 32767;
        return coord_t'(v);
    endfunction

    // mostly well-formed polylines; a few stray first_point flags and missing starts.
    // carry_on keeps the previous polyline going across a register change.
    task automatic run_polylines(input int n_items, input bit carry_on);
        row_t r;
        int   sent, len, k;
        sent = 0;
        while (sent < n_items)
        begin
            len = $urandom_range(12, 1);
            for (k = 0; k < len; k++)
            begin
                r = checked_row(0, 0, 1'b0);
                if (k == 0)
                    r.v.first_point = (carry_on && sent == 0) ? 1'b0 : ($urandom_range(15) != 0);
                else
                    r.v.first_point = ($urandom_range(29) == 0);
                r.v.point_x = rand_near(clip_box.clip_left, clip_box.clip_right);
                r.v.point_y = rand_near(clip_box.clip_top, clip_box.clip_bottom);
                pace_sender();
                send_vertex(r);
                sent++;
            end
        end
    endtask

    task automatic run_phase(input int l, input int r, input int t, input int b,
                             input bit carry_on, input int n_items);
        settle();
        write_reg(REG_CLIP_LEFT,   coord_t'(l));
        write_reg(REG_CLIP_RIGHT,  coord_t'(r));
        write_reg(REG_CLIP_TOP,    coord_t'(t));
        write_reg(REG_CLIP_BOTTOM, coord_t'(b));
        if ($urandom_range(1) == 0)
            write_reg(REG_UNMAPPED, coord_t'($urandom));
        @(negedge clk);
        cfg_valid <= 1'b0;
        run_polylines(n_items, carry_on);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        int lo_a, lo_b;
        clip_box.clip_left   = RST_CLIP_LEFT;
        clip_box.clip_right  = RST_CLIP_RIGHT;
        clip_box.clip_top    = RST_CLIP_TOP;
        clip_box.clip_bottom = RST_CLIP_BOTTOM;
        last_x      = '0;
        last_y      = '0;
        last_inside = 1'b0;

        // directed table, reset rectangle 0..639 by 0..479
        // no first_point after reset: stored vertex is 0,0 flagged outside
        directed_rows.push_back(typed_row(100, 100, 0, 2, CMD_MOVE, 0, 0, CMD_LINE, 100, 100));
        directed_rows.push_back(typed_row(200, 150, 0, 1, CMD_LINE, 200, 150, CMD_MOVE, 0, 0));
        // leave through the right edge on a horizontal
        directed_rows.push_back(typed_row(700, 150, 0, 2, CMD_MOVE, 200, 150,
                                          CMD_LINE, 639, 150));
        // outside to outside: nothing
        directed_rows.push_back(typed_row(800, -50, 0, 0, CMD_MOVE, 0, 0, CMD_MOVE, 0, 0));
        directed_rows.push_back(typed_row(300, -100, 0, 0, CMD_MOVE, 0, 0, CMD_MOVE, 0, 0));
        // enter through the top edge on a vertical
        directed_rows.push_back(typed_row(300, 100, 0, 2, CMD_MOVE, 300, 0, CMD_LINE, 300, 100));
        // coordinate extremes
        directed_rows.push_back(typed_row(-32768, -32768, 1, 1, CMD_MOVE, -32768, -32768,
                                          CMD_MOVE, 0, 0));
        directed_rows.push_back(typed_row(32767, 32767, 0, 0, CMD_MOVE, 0, 0, CMD_MOVE, 0, 0));
        directed_rows.push_back(typed_row(32767, 32767, 1, 1, CMD_MOVE, 32767, 32767,
                                          CMD_MOVE, 0, 0));
        directed_rows.push_back(checked_row(320, 240, 0));
        directed_rows.push_back(checked_row(-32768, 240, 0));
        directed_rows.push_back(typed_row(320, 240, 1, 1, CMD_MOVE, 320, 240, CMD_MOVE, 0, 0));
        directed_rows.push_back(checked_row(320, -32768, 0));
        // corners, edges inclusive
        directed_rows.push_back(typed_row(0, 0, 1, 1, CMD_MOVE, 0, 0, CMD_MOVE, 0, 0));
        directed_rows.push_back(typed_row(639, 479, 0, 1, CMD_LINE, 639, 479, CMD_MOVE, 0, 0));
        directed_rows.push_back(checked_row(640, 480, 0));
        directed_rows.push_back(typed_row(-1, -1, 1, 1, CMD_MOVE, -1, -1, CMD_MOVE, 0, 0));
        directed_rows.push_back(checked_row(0, 0, 0));
        // right edge hit lands above the top, so the top edge is taken instead
        directed_rows.push_back(typed_row(600, 10, 1, 1, CMD_MOVE, 600, 10, CMD_MOVE, 0, 0));
        directed_rows.push_back(checked_row(1000, -500, 0));
        directed_rows.push_back(checked_row(-300, 700, 0));
        directed_rows.push_back(checked_row(5, 470, 0));
        directed_rows.push_back(checked_row(639, 0, 0));
        directed_rows.push_back(checked_row(-32768, 32767, 0));

        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            pace_sender();
            send_vertex(directed_rows[i]);
        end

        // random phases; carry_on ones change the box mid-polyline (stale inside flag)
        run_phase(-100, 100, -50, 50, 1, 180);
        run_phase(-32768, 32767, -32768, 32767, 0, 160);
        run_phase(100, -100, 0, 479, 1, 160);              // inverted: nothing inside
        run_phase(5, 5, -7, -7, 1, 160);                   // single point
        run_phase(32767, 32767, -32768, -32768, 1, 160);   // single point at the extremes
        lo_a = $urandom_range(2000) - 1000;
        lo_b = $urandom_range(2000) - 1000;
        run_phase(lo_a, lo_a + $urandom_range(1500), lo_b, lo_b + $urandom_range(1500),
                  $urandom_range(1), 180);
        run_phase(int'(coord_t'($urandom)), int'(coord_t'($urandom)),
                  int'(coord_t'($urandom)), int'(coord_t'($urandom)), 1, 160);
        run_phase(0, 639, 0, 479, 1, 180);

        settle();
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #8000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

[sim.f]
design/pcrc_pkg.sv
design/pcrc_fifo.sv
design/pcrc_front.sv
design/pcrc_back.sv
design/polyline_rect_clipper_top.sv
verif/tb_polyline_rect_clipper_top.sv
